// ----- hdl/bli_pkg.sv -----
`timescale 1ns / 1ps

package bli_pkg;

  localparam int DEPTH  = 16;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LIST   = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

// ----- hdl/bounded_list_insert_delete_top.sv -----
`timescale 1ns / 1ps

// channel | dir | tdata         | tuser          | tlast
// --------+-----+---------------+----------------+----------------------
// in_     | in  | operand [31:0]| operation [1:0]| -
// out_    | out | element [31:0]| status [1:0]   | last result of a word
//
// An insert moves every entry up one place and writes the operand at the
// head; a delete at position p moves the entries behind it down one place;
// a list reads out each entry in turn. One entry moves per cycle through the
// single store write port. Reset clears the element count; store contents
// stay undefined. in_tready is high only while idle; a held result on out_
// does not block taking the next word, only delivering its own result.

module bounded_list_insert_delete_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [bli_pkg::WORD_W-1:0]   in_tdata,   // operand
  input  logic [bli_pkg::OP_W-1:0]     in_tuser,   // operation
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [bli_pkg::WORD_W-1:0]   out_tdata,  // element
  output logic [bli_pkg::ST_W-1:0]     out_tuser,  // status
  output logic                         out_tlast
);

  import bli_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_FINISH,
    S_RESP,
    S_LIST_RD,
    S_LIST_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  op_t                 op_r, op_nxt;
  logic [WORD_W-1:0]   arg_r, arg_nxt;
  logic [AW-1:0]       cur_r, cur_nxt;
  logic [CW-1:0]       rem_r, rem_nxt;
  logic                wr_vld_r, wr_vld_nxt;
  logic [AW-1:0]       wr_addr_r, wr_addr_nxt;
  status_t             st_r, st_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [WORD_W-1:0]   out_elem_r, out_elem_nxt;
  status_t             out_st_r, out_st_nxt;
  logic                out_last_r, out_last_nxt;

  logic [WORD_W-1:0]   mem [DEPTH];
  logic [WORD_W-1:0]   rd_data_r;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [AW-1:0]       mem_raddr;
  logic [WORD_W-1:0]   mem_wdata;

  logic                out_free;
  logic                list_end;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_elem_r;
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_tvalid_r || out_tready;
  assign list_end   = ((CW'(cur_r) + CW'(1)) == cnt_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    arg_nxt        = arg_r;
    cur_nxt        = cur_r;
    rem_nxt        = rem_r;
    wr_vld_nxt     = wr_vld_r;
    wr_addr_nxt    = wr_addr_r;
    st_nxt         = st_r;
    out_tvalid_nxt = out_tvalid_r;
    out_elem_nxt   = out_elem_r;
    out_st_nxt     = out_st_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = wr_addr_r;
    mem_wdata      = rd_data_r;
    mem_raddr      = cur_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt  = op_t'(in_tuser);
          arg_nxt = in_tdata;
          case (op_t'(in_tuser))
            OP_INSERT: begin
              if (cnt_r == CW'(DEPTH)) begin
                st_nxt    = ST_FULL;
                state_nxt = S_RESP;
              end else begin
                st_nxt    = ST_OK;
                cur_nxt   = AW'(cnt_r - CW'(1));
                rem_nxt   = cnt_r;
                state_nxt = (cnt_r == '0) ? S_FINISH : S_SHIFT;
              end
            end
            OP_DELETE: begin
              if (cnt_r == '0) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_RESP;
              end else if (in_tdata[WORD_W-1] || (in_tdata == '0) ||
                           (in_tdata[WORD_W-2:0] > (WORD_W-1)'(cnt_r))) begin
                st_nxt    = ST_NOT_FOUND;
                state_nxt = S_RESP;
              end else begin
                st_nxt    = ST_OK;
                cur_nxt   = in_tdata[AW-1:0];
                rem_nxt   = cnt_r - in_tdata[CW-1:0];
                state_nxt = (cnt_r == in_tdata[CW-1:0]) ? S_FINISH : S_SHIFT;
              end
            end
            OP_LIST: begin
              if (cnt_r == '0) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                cur_nxt   = '0;
                state_nxt = S_LIST_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_SHIFT: begin
        mem_we = wr_vld_r;
        if (rem_r != '0) begin
          wr_vld_nxt = 1'b1;
          rem_nxt    = rem_r - CW'(1);
          if (op_r == OP_INSERT) begin
            wr_addr_nxt = cur_r + AW'(1);
            cur_nxt     = cur_r - AW'(1);
          end else begin
            wr_addr_nxt = cur_r - AW'(1);
            cur_nxt     = cur_r + AW'(1);
          end
        end else begin
          wr_vld_nxt = 1'b0;
          state_nxt  = S_FINISH;
        end
      end

      S_FINISH: begin
        if (op_r == OP_INSERT) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = arg_r;
          cnt_nxt   = cnt_r + CW'(1);
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_st_nxt     = st_r;
          out_elem_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_LIST_RD: begin
        state_nxt = S_LIST_OUT;
      end

      S_LIST_OUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_st_nxt     = ST_OK;
          out_elem_nxt   = rd_data_r;
          out_last_nxt   = list_end;
          if (list_end) begin
            state_nxt = S_IDLE;
          end else begin
            cur_nxt   = cur_r + AW'(1);
            state_nxt = S_LIST_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      wr_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      op_r         <= op_nxt;
      arg_r        <= arg_nxt;
      cur_r        <= cur_nxt;
      rem_r        <= rem_nxt;
      wr_vld_r     <= wr_vld_nxt;
      wr_addr_r    <= wr_addr_nxt;
      st_r         <= st_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      out_elem_r   <= out_elem_nxt;
      out_st_r     <= out_st_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("element count above depth");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_INSERT) && (cnt_r == CW'(DEPTH)))
    |=> $stable(cnt_r))
    else $error("insert into full list changed count");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + CW'(1)) ||
    (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("count moved by more than one");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_OK)) |-> (out_tlast && (out_tdata == '0)))
    else $error("error result not a single final word");

endmodule
